/* hdl/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way sorted merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

   // fixed field widths
   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 2;
   localparam int IDX_W    = 3;
   localparam int STATUS_W = 2;

   // widest list index, read pointer and fill count the cells ever carry
   localparam int MAX_LW = 6;
   localparam int MAX_PW = 12;
   localparam int MAX_FW = 13;

   // request modes
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // command bundle broadcast to every cell
   typedef struct packed {
      logic                      append;
      logic                      pop;
      logic                      load;
      logic                      clear;
      logic [MAX_LW-1:0]         target;
      logic signed [VALUE_W-1:0] value;
   } kwm_ctl_type;

   // running minimum handed down the cell chain
   typedef struct packed {
      logic                      valid;
      logic [MAX_LW-1:0]         idx;
      logic signed [VALUE_W-1:0] value;
   } kwm_cand_type;

   // queue status reported by each cell
   typedef struct packed {
      logic [MAX_FW-1:0] fill;
      logic [MAX_PW-1:0] rd;
      logic [MAX_PW-1:0] wr;
   } kwm_stat_type;

endpackage

/* hdl/kwm_if.sv */
// ----------------------------------------------------------------------------
// kwm_req_if / kwm_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface kwm_req_if;
   logic                                valid;
   logic                                ready;
   logic [kwm_pkg::MODE_W-1:0]          mode;
   logic [kwm_pkg::IDX_W-1:0]           list_index;
   logic signed [kwm_pkg::VALUE_W-1:0]  value;

   modport source (output valid, mode, list_index, value, input ready);
   modport sink   (input valid, mode, list_index, value, output ready);
endinterface

interface kwm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [kwm_pkg::VALUE_W-1:0]  merged_value;
   logic [kwm_pkg::IDX_W-1:0]           source_list;
   logic [kwm_pkg::STATUS_W-1:0]        status;

   modport source (output valid, merged_value, source_list, status, input ready);
   modport sink   (input valid, merged_value, source_list, status, output ready);
endinterface

/* hdl/k_way_sorted_merge.sv */
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merges up to NUM_LISTS ascending queues of signed values, smallest head first.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  req_ch   | in  | valid/ready   | mode, list_index, value
//  rsp_ch   | out | valid/ready   | merged_value, source_list, status
//
//  Load, clear and unknown modes are answered from the idle state; a pop runs
//  the head-minimum search that walks the chain of list cells one cell per
//  cycle, followed by the element RAM read that refills the head.
//  One request is in flight at a time; a new beat is taken once the response
//  register is empty or being drained. Synchronous reset empties every list.
// ----------------------------------------------------------------------------
module k_way_sorted_merge #(
   parameter int NUM_LISTS  = 8,
   parameter int LIST_DEPTH = 64
) (
   input logic      clock,
   input logic      reset,
   kwm_req_if.sink   req_ch,
   kwm_rsp_if.source rsp_ch
);

   localparam int LW    = $clog2(NUM_LISTS);
   localparam int PW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int FW    = $clog2(LIST_DEPTH + 1);
   localparam int DEPTH = NUM_LISTS * LIST_DEPTH;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_READ = 5'b00100,
      S_LOAD = 5'b01000,
      S_SPARE = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [LW-1:0]                      scan_cnt_ff, scan_cnt_in;
   logic [LW-1:0]                      win_lst_ff, win_lst_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [kwm_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [kwm_pkg::IDX_W-1:0]          rsp_src_ff, rsp_src_in;
   logic [kwm_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   kwm_pkg::kwm_ctl_type               ctl;
   kwm_pkg::kwm_cand_type              chain [NUM_LISTS+1];
   kwm_pkg::kwm_stat_type              stat  [NUM_LISTS];
   kwm_pkg::kwm_cand_type              win;

   logic                               accept;
   logic                               req_range_ok;
   logic [LW-1:0]                      req_lst;
   logic [LW-1:0]                      chain_lst;
   logic                               req_full;
   logic [PW-1:0]                      win_rd, win_rd_inc;
   logic                               ram_we;
   logic [AW-1:0]                      ram_waddr, ram_raddr;
   logic [kwm_pkg::VALUE_W-1:0]        ram_rdata;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_range_ok = ({29'd0, req_ch.list_index} < NUM_LISTS);
   assign req_lst      = LW'(req_ch.list_index);
   assign req_full     = !req_range_ok || (stat[req_lst].fill == kwm_pkg::MAX_FW'(LIST_DEPTH));
   assign win          = chain[NUM_LISTS];
   assign chain_lst    = win.idx[LW-1:0];
   assign win_rd       = stat[chain_lst].rd[PW-1:0];
   assign win_rd_inc   = (win_rd == PW'(LIST_DEPTH - 1)) ? '0 : win_rd + 1'b1;

   // element RAM: append writes, pop reads the next head
   assign ram_we    = ctl.append;
   assign ram_waddr = AW'(req_lst) * AW'(LIST_DEPTH) + AW'(stat[req_lst].wr[PW-1:0]);
   assign ram_raddr = AW'(chain_lst) * AW'(LIST_DEPTH) + AW'(win_rd_inc);

   kwm_ram #(
      .WIDTH (kwm_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ch.value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // build the cell command
   always_comb begin
      ctl.append = 1'b0;
      ctl.pop    = 1'b0;
      ctl.load   = 1'b0;
      ctl.clear  = 1'b0;
      ctl.target = kwm_pkg::MAX_LW'(req_lst);
      ctl.value  = req_ch.value;
      case (state_ff)
         S_IDLE: begin
            ctl.append = accept && (req_ch.mode == kwm_pkg::MODE_LOAD) && !req_full;
            ctl.clear  = accept && (req_ch.mode == kwm_pkg::MODE_CLEAR);
         end
         S_READ: begin
            ctl.pop    = win.valid;
            ctl.target = kwm_pkg::MAX_LW'(chain_lst);
         end
         S_LOAD: begin
            ctl.load   = (stat[win_lst_ff].fill != '0);
            ctl.target = kwm_pkg::MAX_LW'(win_lst_ff);
            ctl.value  = ram_rdata;
         end
         default: begin
         end
      endcase
   end

   // row of list cells, candidate handed along each cycle
   assign chain[0] = '0;

   for (genvar i = 0; i < NUM_LISTS; i++) begin : g_cell
      kwm_cell #(
         .LIST_DEPTH (LIST_DEPTH),
         .CELL_ID    (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .cand_in  (chain[i]),
         .cand_out (chain[i+1]),
         .stat     (stat[i])
      );
   end

   // sequence one request and fill the response register
   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      win_lst_in    = win_lst_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_src_in    = '0;
               rsp_status_in = kwm_pkg::ST_OK;
               if (req_ch.mode == kwm_pkg::MODE_POP) begin
                  state_in    = S_SCAN;
                  scan_cnt_in = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  if ((req_ch.mode == kwm_pkg::MODE_LOAD) && req_full) begin
                     rsp_status_in = kwm_pkg::ST_FULL;
                  end
               end
            end
         end
         S_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == LW'(NUM_LISTS - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            win_lst_in   = chain_lst;
            if (win.valid) begin
               rsp_value_in  = win.value;
               rsp_src_in    = win.idx[kwm_pkg::IDX_W-1:0];
               rsp_status_in = kwm_pkg::ST_OK;
               state_in      = S_LOAD;
            end else begin
               rsp_value_in  = '0;
               rsp_src_in    = '0;
               rsp_status_in = kwm_pkg::ST_EMPTY;
               state_in      = S_IDLE;
            end
         end
         S_LOAD: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_lst_ff    <= win_lst_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.merged_value = rsp_value_ff;
   assign rsp_ch.source_list  = rsp_src_ff;
   assign rsp_ch.status       = rsp_status_ff;

`ifndef ASSERT_OFF
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register lost one-hot encoding");

   a_pop_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.mode == kwm_pkg::MODE_POP)) |=> (state_ff == S_SCAN))
      else $error("pop beat did not start the chain scan");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && (scan_cnt_ff == LW'(NUM_LISTS - 1))) |=>
      (state_ff == S_READ))
      else $error("chain scan did not end after one pass");

   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_READ) && win.valid) |=>
      (rsp_valid_ff && (rsp_status_ff == kwm_pkg::ST_OK)))
      else $error("found head was not presented as an ok response");
`endif

endmodule

/* hdl/kwm_ram.sv */
// ----------------------------------------------------------------------------
// kwm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/kwm_cell.sv */
// ----------------------------------------------------------------------------
// kwm_cell
// One list: queue pointers, fill count, cached head value and one stage of
// the minimum search chain.
// ----------------------------------------------------------------------------
module kwm_cell #(
   parameter int LIST_DEPTH = 64,
   parameter int CELL_ID    = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kwm_pkg::kwm_ctl_type  ctl,
   input  kwm_pkg::kwm_cand_type cand_in,
   output kwm_pkg::kwm_cand_type cand_out,
   output kwm_pkg::kwm_stat_type stat
);

   localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int FW = $clog2(LIST_DEPTH + 1);

   logic [FW-1:0]                      fill_ff, fill_in;
   logic [PW-1:0]                      rd_ff, rd_in, rd_inc;
   logic [PW-1:0]                      wr_ff, wr_in, wr_inc;
   logic signed [kwm_pkg::VALUE_W-1:0] head_ff, head_in;
   kwm_pkg::kwm_cand_type              cand_ff, cand_in_next;
   logic                               hit;
   logic                               empty;

   assign hit    = (ctl.target == kwm_pkg::MAX_LW'(CELL_ID));
   assign empty  = (fill_ff == '0);
   assign rd_inc = (rd_ff == PW'(LIST_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   assign wr_inc = (wr_ff == PW'(LIST_DEPTH - 1)) ? '0 : wr_ff + 1'b1;

   // update queue state from the broadcast command
   always_comb begin
      fill_in = fill_ff;
      rd_in   = rd_ff;
      wr_in   = wr_ff;
      head_in = head_ff;
      if (ctl.clear) begin
         fill_in = '0;
         rd_in   = '0;
         wr_in   = '0;
      end else if (hit) begin
         if (ctl.append && (fill_ff != FW'(LIST_DEPTH))) begin
            wr_in   = wr_inc;
            fill_in = fill_ff + 1'b1;
            if (empty) begin
               head_in = ctl.value;
            end
         end
         if (ctl.pop && !empty) begin
            rd_in   = rd_inc;
            fill_in = fill_ff - 1'b1;
         end
         if (ctl.load) begin
            head_in = ctl.value;
         end
      end
   end

   // keep the smaller of the incoming candidate and this head; ties stay upstream
   always_comb begin
      cand_in_next = cand_in;
      if (!empty && (!cand_in.valid || (head_ff < cand_in.value))) begin
         cand_in_next.valid = 1'b1;
         cand_in_next.idx   = kwm_pkg::MAX_LW'(CELL_ID);
         cand_in_next.value = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rd_ff         <= '0;
         wr_ff         <= '0;
         cand_ff.valid <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
         cand_ff.valid <= cand_in_next.valid;
      end
      head_ff       <= head_in;
      cand_ff.idx   <= cand_in_next.idx;
      cand_ff.value <= cand_in_next.value;
   end

   assign cand_out  = cand_ff;
   assign stat.fill = kwm_pkg::MAX_FW'(fill_ff);
   assign stat.rd   = kwm_pkg::MAX_PW'(rd_ff);
   assign stat.wr   = kwm_pkg::MAX_PW'(wr_ff);

endmodule

/* tb/kwm_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_tb_pkg
// Request and response beat types as the testbench queues them.
// ----------------------------------------------------------------------------
package kwm_tb_pkg;

   // one request beat as the testbench queues it
   typedef struct packed {
      logic [kwm_pkg::MODE_W-1:0]         mode;
      logic [kwm_pkg::IDX_W-1:0]          list_index;
      logic signed [kwm_pkg::VALUE_W-1:0] value;
   } merge_req_type;

   // one response beat as the testbench expects it
   typedef struct packed {
      logic signed [kwm_pkg::VALUE_W-1:0] merged_value;
      logic [kwm_pkg::IDX_W-1:0]          source_list;
      logic [kwm_pkg::STATUS_W-1:0]       status;
   } merge_rsp_type;
endpackage

/* tb/k_way_sorted_merge_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_tb
// Drives load, pop, clear and unknown-mode beats into the merge block with
// random idling on both sides. A behavioral list/heap model predicts every
// response, and the monitor checks each response beat in order.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_tb;

   localparam int NLISTS = 8;
   localparam int DEPTH  = 64;
   localparam int POSW   = 2 * DEPTH;
   localparam int WDOG   = 20000;
   localparam logic [kwm_pkg::MODE_W-1:0] MODE_UNKNOWN = 2'd3;

   logic clock;
   logic reset;

   kwm_req_if req_ch ();
   kwm_rsp_if rsp_ch ();

   k_way_sorted_merge #(.NUM_LISTS(NLISTS), .LIST_DEPTH(DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // list contents of the model
   logic signed [kwm_pkg::VALUE_W-1:0] list_mem [NLISTS][DEPTH];
   int                        rd_pos [NLISTS];
   int                        wr_pos [NLISTS];
   int                        heap [NLISTS];
   int                        heap_len;

   kwm_tb_pkg::merge_req_type pending_reqs[$];
   kwm_tb_pkg::merge_rsp_type expected_rsps[$];

   int  errors;
   int  quiet_cycles;
   bit  drain_mode;     // no idling on either side
   bit  rsp_hold;       // receiver held off
   int  hold_cycles;
   bit  req_taken;      // request beat taken at the last rising edge

   // ---------------------------------------------------------------------
   // merge model
   // ---------------------------------------------------------------------
   function automatic int fill_of(int l);
      return (wr_pos[l] + POSW - rd_pos[l]) % POSW;
   endfunction

   function automatic logic signed [kwm_pkg::VALUE_W-1:0] head_of(int l);
      return list_mem[l][rd_pos[l] % DEPTH];
   endfunction

   function automatic bit ranks_first(int a, int b);
      return head_of(a) < head_of(b) || (head_of(a) == head_of(b) && a < b);
   endfunction

   function automatic void heap_swap(int i, int j);
      int t;
      t = heap[i];
      heap[i] = heap[j];
      heap[j] = t;
   endfunction

   function automatic void sift_toward_root(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ranks_first(heap[i], heap[p])) break;
         heap_swap(i, p);
         i = p;
      end
   endfunction

   function automatic void sift_toward_leaves(int i);
      int lc, m;
      forever begin
         lc = 2 * i + 1;
         m  = i;
         if (lc < heap_len && ranks_first(heap[lc], heap[m])) m = lc;
         if (lc + 1 < heap_len && ranks_first(heap[lc + 1], heap[m])) m = lc + 1;
         if (m == i) break;
         heap_swap(i, m);
         i = m;
      end
   endfunction

   function automatic kwm_tb_pkg::merge_rsp_type merge_predict(
      kwm_tb_pkg::merge_req_type r);
      kwm_tb_pkg::merge_rsp_type o;
      int l;
      bit was_empty;
      o = '0;
      o.status = kwm_pkg::ST_OK;
      case (r.mode)
         kwm_pkg::MODE_LOAD: begin
            l = r.list_index;
            if (l >= NLISTS || fill_of(l) >= DEPTH) begin
               o.status = kwm_pkg::ST_FULL;
            end else begin
               was_empty = fill_of(l) == 0;
               list_mem[l][wr_pos[l] % DEPTH] = r.value;
               wr_pos[l] = (wr_pos[l] + 1) % POSW;
               if (was_empty && heap_len < NLISTS) begin
                  heap[heap_len] = l;
                  heap_len++;
                  sift_toward_root(heap_len - 1);
               end
            end
         end
         kwm_pkg::MODE_POP: begin
            if (heap_len == 0) begin
               o.status = kwm_pkg::ST_EMPTY;
            end else begin
               l = heap[0];
               o.merged_value = head_of(l);
               o.source_list  = l[kwm_pkg::IDX_W-1:0];
               rd_pos[l] = (rd_pos[l] + 1) % POSW;
               if (fill_of(l) == 0) begin
                  heap_len--;
                  heap[0] = heap[heap_len];
               end
               if (heap_len > 0) sift_toward_leaves(0);
            end
         end
         kwm_pkg::MODE_CLEAR: begin
            foreach (rd_pos[i]) begin
               rd_pos[i] = 0;
               wr_pos[i] = 0;
            end
            heap_len = 0;
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // ---------------------------------------------------------------------
   // request driver: change at falling edge
   // ---------------------------------------------------------------------
   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = kwm_pkg::MODE_LOAD;
      req_ch.list_index = '0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
   end

   // record the request handshake at the edge where it happens
   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
   end

   always @(negedge clock) begin
      kwm_tb_pkg::merge_req_type r;
      bit accepted;
      accepted = req_taken;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !accepted) begin
         // hold the beat until taken
      end else if (pending_reqs.size() != 0 &&
                   (drain_mode || $urandom_range(99) >= 34)) begin
         r = pending_reqs.pop_front();
         req_ch.valid      <= 1'b1;
         req_ch.mode       <= r.mode;
         req_ch.list_index <= r.list_index;
         req_ch.value      <= r.value;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // receiver ready
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= drain_mode || $urandom_range(99) >= 34;
      end
   end

   // long receiver hold-off, counted in its own process
   initial begin
      rsp_hold = 1'b0;
      wait (hold_cycles > 0);
      rsp_hold = 1'b1;
      repeat (hold_cycles) @(posedge clock);
      @(negedge clock);
      rsp_hold = 1'b0;
   end

   // ---------------------------------------------------------------------
   // monitor: predict on request beat, check on response beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      kwm_tb_pkg::merge_req_type r;
      kwm_tb_pkg::merge_rsp_type e;
      bit busy;
      if (!reset) begin
         busy = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            r.mode = req_ch.mode;
            r.list_index = req_ch.list_index;
            r.value = req_ch.value;
            expected_rsps.push_back(merge_predict(r));
            busy = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            busy = 1'b1;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response beat");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_ch.merged_value !== e.merged_value) begin
                  $error("merged_value: expected %0d, got %0d", e.merged_value,
                         rsp_ch.merged_value);
                  errors++;
               end
               if (rsp_ch.source_list !== e.source_list) begin
                  $error("source_list: expected %0d, got %0d", e.source_list,
                         rsp_ch.source_list);
                  errors++;
               end
               if (rsp_ch.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_ch.status);
                  errors++;
               end
            end
         end
         quiet_cycles <= busy ? 0 : quiet_cycles + 1;
      end
   end

   // watchdog on cycles with no accepted beat
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (quiet_cycles > WDOG) begin
            $display("k_way_sorted_merge: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic kwm_tb_pkg::merge_req_type mk(logic [kwm_pkg::MODE_W-1:0] m,
                                                     int l, logic [31:0] v);
      kwm_tb_pkg::merge_req_type r;
      r.mode = m;
      r.list_index = l[kwm_pkg::IDX_W-1:0];
      r.value = v;
      return r;
   endfunction

   // queue sorted runs of appends on randomly chosen lists, then pops and now and then a clear
   task automatic add_merge_round();
      int nl, n, base, l;
      nl = $urandom_range(1, NLISTS);
      for (int k = 0; k < nl; k++) begin
         l = $urandom_range(NLISTS - 1);
         n = $urandom_range(1, 6);
         base = $urandom_range(7) == 0 ? $urandom : int'($urandom_range(40)) - 20;
         for (int j = 0; j < n; j++) begin
            pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, l, base));
            base += $urandom_range(3);
         end
      end
      n = $urandom_range(4, 30);
      for (int j = 0; j < n; j++) pending_reqs.push_back(mk(kwm_pkg::MODE_POP, 0, 0));
      if ($urandom_range(9) == 0) pending_reqs.push_back(mk(kwm_pkg::MODE_CLEAR, 0, 0));
   endtask

   task automatic wait_all_done();
      wait (pending_reqs.size() == 0 && !req_ch.valid);
      wait (expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int t;
      errors = 0;
      quiet_cycles = 0;
      drain_mode = 1'b0;
      hold_cycles = 0;
      heap_len = 0;
      foreach (rd_pos[i]) begin
         rd_pos[i] = 0;
         wr_pos[i] = 0;
      end
      wait (!reset);

      // directed: empty pop, extremes, ties, unknown mode, clear
      pending_reqs.push_back(mk(kwm_pkg::MODE_POP, 0, 0));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 7, 32'h7fffffff));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 0, 32'h80000000));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 3, 5));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 5, 5));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 2, 32'hffffffff));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 2, 32'h00000000));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 6, 3));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 6, 1));   // descending list
      pending_reqs.push_back(mk(MODE_UNKNOWN, 7, 32'h5a5a5a5a));
      for (int j = 0; j < 9; j++) pending_reqs.push_back(mk(kwm_pkg::MODE_POP, 0, 0));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 1, 9));
      pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 4, 32'haaaaaaaa));
      pending_reqs.push_back(mk(kwm_pkg::MODE_CLEAR, 0, 0));
      pending_reqs.push_back(mk(kwm_pkg::MODE_POP, 0, 0));

      // fill one list past full, no idling, then receiver hold-off
      drain_mode = 1'b1;
      for (int j = 0; j < DEPTH + 2; j++)
         pending_reqs.push_back(mk(kwm_pkg::MODE_LOAD, 4, j));
      hold_cycles = 300;
      wait_all_done();
      drain_mode = 1'b0;
      for (int j = 0; j < DEPTH + 1; j++)
         pending_reqs.push_back(mk(kwm_pkg::MODE_POP, 0, 0));
      // sender pause until every response is in
      wait_all_done();

      // random part
      t = 0;
      while (t < 1150) begin
         if (pending_reqs.size() < 40) begin
            if ($urandom_range(4) == 0) begin
               pending_reqs.push_back(mk(kwm_pkg::MODE_W'($urandom_range(3)),
                                         $urandom_range(7), $urandom));
               t++;
            end else begin
               t -= pending_reqs.size();
               add_merge_round();
               t += pending_reqs.size();
            end
            drain_mode = (t > 500 && t < 650);
         end else begin
            @(posedge clock);
         end
      end
      drain_mode = 1'b0;
      wait_all_done();
      if (errors == 0) begin
         $display("k_way_sorted_merge: match");
      end else begin
         $display("k_way_sorted_merge: mismatch");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/kwm_pkg.sv
hdl/kwm_if.sv
hdl/kwm_ram.sv
hdl/kwm_cell.sv
hdl/k_way_sorted_merge.sv
tb/kwm_tb_if.sv
tb/k_way_sorted_merge_tb.sv
